[design/brf_pkg.sv]
`default_nettype none

package brf_pkg;

	localparam int DEPTH     = 1024;
	localparam int MAX_BURST = 64;
	localparam int PTR_W     = $clog2(DEPTH);
	localparam int CNT_W     = PTR_W;
	localparam int LEN_W     = 7;
	localparam int KIND_W    = 3;
	localparam int BYTE_W    = 8;
	localparam int STAT_W    = 2;
	localparam int USED_W    = 10;
	localparam int SUM_W     = ((PTR_W > LEN_W) ? PTR_W : LEN_W) + 1;
	localparam int QDEPTH    = 4;
	localparam int QPTR_W    = $clog2(QDEPTH);
	localparam int QCNT_W    = $clog2(QDEPTH + 1);

	localparam logic [KIND_W-1:0] KIND_ENQ   = 3'd0;
	localparam logic [KIND_W-1:0] KIND_DEQ   = 3'd1;
	localparam logic [KIND_W-1:0] KIND_PEEK  = 3'd2;
	localparam logic [KIND_W-1:0] KIND_SKIP  = 3'd3;
	localparam logic [KIND_W-1:0] KIND_RESV  = 3'd4;
	localparam logic [KIND_W-1:0] KIND_CLEAR = 3'd5;

	localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
	localparam logic [STAT_W-1:0] ST_NO_DATA  = 2'd1;
	localparam logic [STAT_W-1:0] ST_NO_SPACE = 2'd2;

	typedef enum logic [1:0] {
		OP_PLAIN,
		OP_WRITE,
		OP_READ
	} op_t;

	typedef struct packed {
		op_t                 op;
		logic [STAT_W-1:0]   status;
		logic [BYTE_W-1:0]   data;
		logic [LEN_W-1:0]    count;
		logic                last;
		logic [USED_W-1:0]   used;
		logic [PTR_W-1:0]    addr;
	} entry_t;

	function automatic logic [PTR_W-1:0] adv(input logic [PTR_W-1:0] p,
		input logic [LEN_W-1:0] n);
		logic [SUM_W-1:0] s;
		s = SUM_W'(p) + SUM_W'(n);
		if (s >= SUM_W'(DEPTH)) begin
			s = s - SUM_W'(DEPTH);
		end
		return s[PTR_W-1:0];
	endfunction

endpackage

`default_nettype wire

[design/byte_ring_fifo_burst.sv]
// Byte ring FIFO with whole-burst operations.
// Input stream (s_*): one transfer per command or per enqueued byte.
//   s_tuser carries kind and the first-byte flag, s_tdata carries length and
//   the byte. An enqueue burst is one transfer per byte, the first flagged.
// Output stream (m_*): one transfer per result. Dequeue and peek produce one
//   transfer per byte read, m_tlast on the final one; every other command
//   produces one transfer. m_tuser carries the status code.
// The first result of a command passes through the command queue, the
//   pending stage and the result register. A dequeue or peek holds the result
//   side until its last byte is read, one byte per cycle while m_tready does
//   not stall it, from the single read port of the byte store.
// A four-entry command queue sits between the decoder and the result side;
//   s_tready drops while it is full.
// When m_tready is low the result register holds, the result side halts, and
//   the queue fills before the input side stalls.
// Reset empties the FIFO (pointers and counts to zero); store contents stay
//   undefined and are not swept.
`default_nettype none

module byte_ring_fifo_burst (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [15:0] s_tdata,  // length[6:0], data_byte[14:7], zero[15]
	input  wire logic [3:0]  s_tuser,  // kind[2:0], first[3]
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [31:0]      m_tdata,  // out_byte[7:0], done_count[14:8], used_count[24:15]
	output logic [1:0]       m_tuser,  // status[1:0]
	output logic             m_tlast
);

	brf_pkg::entry_t              push_ent, head;
	logic                         push, q_full, q_empty, pop;
	logic [brf_pkg::BYTE_W-1:0]   out_byte;
	logic [brf_pkg::LEN_W-1:0]    out_count;
	logic [brf_pkg::USED_W-1:0]   out_used;

	brf_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.kind      (s_tuser[2:0]),
		.length    (s_tdata[6:0]),
		.data_byte (s_tdata[14:7]),
		.first     (s_tuser[3]),
		.q_full    (q_full),
		.push      (push),
		.ent       (push_ent)
	);

	brf_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_ent (push_ent),
		.full     (q_full),
		.pop      (pop),
		.head     (head),
		.empty    (q_empty)
	);

	brf_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.q_empty    (q_empty),
		.pop        (pop),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_status (m_tuser),
		.out_byte   (out_byte),
		.out_count  (out_count),
		.out_last   (m_tlast),
		.out_used   (out_used)
	);

	assign m_tdata = {7'd0, out_used, out_count, out_byte};

endmodule

`default_nettype wire

[design/brf_front.sv]
`default_nettype none

module brf_front (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic [brf_pkg::KIND_W-1:0]    kind,
	input  wire logic [brf_pkg::LEN_W-1:0]     length,
	input  wire logic [brf_pkg::BYTE_W-1:0]    data_byte,
	input  wire logic                          first,
	input  wire logic                          q_full,
	output logic                               push,
	output brf_pkg::entry_t                    ent
);

	logic [brf_pkg::PTR_W-1:0] rp_q, rp_d, wp_q, wp_d;
	logic [brf_pkg::CNT_W-1:0] used_q, used_d, free_bytes;
	logic [brf_pkg::LEN_W-1:0] bl_q, bl_d, bl_cur, len_sat;
	logic                      ok_q, ok_d, ok_cur;

	assign in_ready = !q_full;
	assign push     = in_valid && in_ready;

	always_comb begin
		len_sat = (length > brf_pkg::LEN_W'(brf_pkg::MAX_BURST)) ?
			brf_pkg::LEN_W'(brf_pkg::MAX_BURST) : length;
		free_bytes = brf_pkg::CNT_W'(brf_pkg::DEPTH - 1) - used_q;
		rp_d   = rp_q;
		wp_d   = wp_q;
		used_d = used_q;
		bl_d   = bl_q;
		ok_d   = ok_q;
		bl_cur = bl_q;
		ok_cur = ok_q;
		ent.op     = brf_pkg::OP_PLAIN;
		ent.status = brf_pkg::ST_OK;
		ent.data   = data_byte;
		ent.count  = '0;
		ent.last   = 1'b1;
		ent.addr   = '0;
		case (kind)
			brf_pkg::KIND_ENQ: begin
				if (first && len_sat == '0) begin
					bl_d = '0;
					ok_d = 1'b0;
				end else if (!first && bl_q == '0) begin
					ent.status = brf_pkg::ST_NO_SPACE;
				end else begin
					bl_cur = first ? len_sat : bl_q;
					ok_cur = first ?
						(brf_pkg::SUM_W'(len_sat) <= brf_pkg::SUM_W'(free_bytes)) : ok_q;
					bl_d     = bl_cur - brf_pkg::LEN_W'(1);
					ent.last = (bl_d == '0);
					if (ok_cur && used_q != brf_pkg::CNT_W'(brf_pkg::DEPTH - 1)) begin
						wp_d      = brf_pkg::adv(wp_q, brf_pkg::LEN_W'(1));
						used_d    = used_q + brf_pkg::CNT_W'(1);
						ent.op    = brf_pkg::OP_WRITE;
						ent.addr  = wp_d;
						ent.count = brf_pkg::LEN_W'(1);
						ok_d      = 1'b1;
					end else begin
						ent.status = brf_pkg::ST_NO_SPACE;
						ok_d       = 1'b0;
					end
					if (bl_d == '0) begin
						ok_d = 1'b0;
					end
				end
			end
			brf_pkg::KIND_CLEAR: begin
				bl_d   = '0;
				ok_d   = 1'b0;
				rp_d   = '0;
				wp_d   = '0;
				used_d = '0;
			end
			brf_pkg::KIND_RESV: begin
				bl_d = '0;
				ok_d = 1'b0;
				if (len_sat != '0) begin
					if (brf_pkg::SUM_W'(len_sat) > brf_pkg::SUM_W'(free_bytes)) begin
						ent.status = brf_pkg::ST_NO_SPACE;
					end else begin
						wp_d      = brf_pkg::adv(wp_q, len_sat);
						used_d    = brf_pkg::CNT_W'(brf_pkg::SUM_W'(used_q) +
							brf_pkg::SUM_W'(len_sat));
						ent.count = len_sat;
					end
				end
			end
			brf_pkg::KIND_DEQ, brf_pkg::KIND_PEEK, brf_pkg::KIND_SKIP: begin
				bl_d = '0;
				ok_d = 1'b0;
				if (len_sat != '0) begin
					if (brf_pkg::SUM_W'(len_sat) > brf_pkg::SUM_W'(used_q)) begin
						ent.status = brf_pkg::ST_NO_DATA;
					end else begin
						ent.count = len_sat;
						if (kind != brf_pkg::KIND_PEEK) begin
							rp_d   = brf_pkg::adv(rp_q, len_sat);
							used_d = brf_pkg::CNT_W'(brf_pkg::SUM_W'(used_q) -
								brf_pkg::SUM_W'(len_sat));
						end
						if (kind != brf_pkg::KIND_SKIP) begin
							ent.op   = brf_pkg::OP_READ;
							ent.addr = brf_pkg::adv(rp_q, brf_pkg::LEN_W'(1));
						end
					end
				end
			end
			default: begin
			end
		endcase
		ent.used = brf_pkg::USED_W'(used_d);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rp_q   <= '0;
			wp_q   <= '0;
			used_q <= '0;
			bl_q   <= '0;
			ok_q   <= 1'b0;
		end else if (push) begin
			rp_q   <= rp_d;
			wp_q   <= wp_d;
			used_q <= used_d;
			bl_q   <= bl_d;
			ok_q   <= ok_d;
		end
	end

	a_used_bound: assert property (@(posedge clk) disable iff (!arst_n)
		used_q <= brf_pkg::CNT_W'(brf_pkg::DEPTH - 1))
		else $error("stored byte count above capacity");

	a_ok_open: assert property (@(posedge clk) disable iff (!arst_n)
		ok_q |-> (bl_q != '0))
		else $error("burst marked good with no bytes left");

endmodule

`default_nettype wire

[design/brf_queue.sv]
`default_nettype none

module brf_queue (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            push,
	input  brf_pkg::entry_t      push_ent,
	output logic                 full,
	input  wire logic            pop,
	output brf_pkg::entry_t      head,
	output logic                 empty
);

	brf_pkg::entry_t            ent_q [brf_pkg::QDEPTH];
	logic [brf_pkg::QPTR_W-1:0] wr_q, rd_q;
	logic [brf_pkg::QCNT_W-1:0] count_q;
	logic                       do_push, do_pop;

	assign full    = (count_q == brf_pkg::QCNT_W'(brf_pkg::QDEPTH));
	assign empty   = (count_q == '0);
	assign head    = ent_q[rd_q];
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;

	function automatic logic [brf_pkg::QPTR_W-1:0] inc(input logic [brf_pkg::QPTR_W-1:0] p);
		return (p == brf_pkg::QPTR_W'(brf_pkg::QDEPTH - 1)) ? '0 : p + brf_pkg::QPTR_W'(1);
	endfunction

	always_ff @(posedge clk) begin
		if (do_push) begin
			ent_q[wr_q] <= push_ent;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= inc(wr_q);
			end
			if (do_pop) begin
				rd_q <= inc(rd_q);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + brf_pkg::QCNT_W'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - brf_pkg::QCNT_W'(1);
			end
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= brf_pkg::QCNT_W'(brf_pkg::QDEPTH))
		else $error("queue count above depth");

endmodule

`default_nettype wire

[design/brf_back.sv]
`default_nettype none

module brf_back (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  brf_pkg::entry_t                  head,
	input  wire logic                        q_empty,
	output logic                             pop,
	output logic                             out_valid,
	input  wire logic                        out_ready,
	output logic [brf_pkg::STAT_W-1:0]       out_status,
	output logic [brf_pkg::BYTE_W-1:0]       out_byte,
	output logic [brf_pkg::LEN_W-1:0]        out_count,
	output logic                             out_last,
	output logic [brf_pkg::USED_W-1:0]       out_used
);

	typedef enum logic {
		ST_IDLE,
		ST_BURST
	} state_t;

	state_t                     state_q;
	logic [brf_pkg::PTR_W-1:0]  addr_q, rd_addr;
	logic [brf_pkg::LEN_W-1:0]  left_q, bcount_q;
	logic [brf_pkg::USED_W-1:0] bused_q;
	logic [brf_pkg::BYTE_W-1:0] mem [brf_pkg::DEPTH];
	logic [brf_pkg::BYTE_W-1:0] rdata_q;

	logic                       pend_valid_s1, pend_rd_s1, pend_last_s1;
	logic [brf_pkg::STAT_W-1:0] pend_status_s1;
	logic [brf_pkg::LEN_W-1:0]  pend_count_s1;
	logic [brf_pkg::USED_W-1:0] pend_used_s1;

	logic                       out_valid_q, out_last_q;
	logic [brf_pkg::STAT_W-1:0] out_status_q;
	logic [brf_pkg::BYTE_W-1:0] out_byte_q;
	logic [brf_pkg::LEN_W-1:0]  out_count_q;
	logic [brf_pkg::USED_W-1:0] out_used_q;

	logic move, issue_ok, wr_en, rd_en, burst_issue;

	assign move        = pend_valid_s1 && (!out_valid_q || out_ready);
	assign issue_ok    = !pend_valid_s1 || move;
	assign pop         = (state_q == ST_IDLE) && !q_empty && issue_ok;
	assign burst_issue = (state_q == ST_BURST) && issue_ok;
	assign wr_en       = pop && (head.op == brf_pkg::OP_WRITE);
	assign rd_en       = (pop && (head.op == brf_pkg::OP_READ)) || burst_issue;
	assign rd_addr     = (state_q == ST_BURST) ? addr_q : head.addr;

	assign out_valid  = out_valid_q;
	assign out_status = out_status_q;
	assign out_byte   = out_byte_q;
	assign out_count  = out_count_q;
	assign out_last   = out_last_q;
	assign out_used   = out_used_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[head.addr] <= head.data;
		end
		if (rd_en) begin
			rdata_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			addr_q         <= '0;
			left_q         <= '0;
			bcount_q       <= '0;
			bused_q        <= '0;
			pend_valid_s1  <= 1'b0;
			pend_rd_s1     <= 1'b0;
			pend_last_s1   <= 1'b0;
			pend_status_s1 <= '0;
			pend_count_s1  <= '0;
			pend_used_s1   <= '0;
			out_valid_q    <= 1'b0;
			out_last_q     <= 1'b0;
			out_status_q   <= '0;
			out_byte_q     <= '0;
			out_count_q    <= '0;
			out_used_q     <= '0;
		end else begin
			if (move) begin
				out_valid_q  <= 1'b1;
				out_status_q <= pend_status_s1;
				out_byte_q   <= pend_rd_s1 ? rdata_q : '0;
				out_count_q  <= pend_count_s1;
				out_last_q   <= pend_last_s1;
				out_used_q   <= pend_used_s1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end

			if (pop) begin
				pend_valid_s1  <= 1'b1;
				pend_status_s1 <= head.status;
				pend_count_s1  <= head.count;
				pend_used_s1   <= head.used;
				if (head.op == brf_pkg::OP_READ) begin
					pend_rd_s1   <= 1'b1;
					pend_last_s1 <= (head.count == brf_pkg::LEN_W'(1));
					if (head.count != brf_pkg::LEN_W'(1)) begin
						state_q  <= ST_BURST;
						addr_q   <= brf_pkg::adv(head.addr, brf_pkg::LEN_W'(1));
						left_q   <= head.count - brf_pkg::LEN_W'(1);
						bcount_q <= head.count;
						bused_q  <= head.used;
					end
				end else begin
					pend_rd_s1   <= 1'b0;
					pend_last_s1 <= head.last;
				end
			end else if (burst_issue) begin
				pend_valid_s1  <= 1'b1;
				pend_rd_s1     <= 1'b1;
				pend_status_s1 <= brf_pkg::ST_OK;
				pend_count_s1  <= bcount_q;
				pend_used_s1   <= bused_q;
				pend_last_s1   <= (left_q == brf_pkg::LEN_W'(1));
				addr_q         <= brf_pkg::adv(addr_q, brf_pkg::LEN_W'(1));
				left_q         <= left_q - brf_pkg::LEN_W'(1);
				if (left_q == brf_pkg::LEN_W'(1)) begin
					state_q <= ST_IDLE;
				end
			end else if (move) begin
				pend_valid_s1 <= 1'b0;
			end
		end
	end

	a_port_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(rd_en && wr_en))
		else $error("store read and written by the same command");

	a_burst_left: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_BURST) |-> (left_q != '0))
		else $error("burst active with no bytes left");

endmodule

`default_nettype wire

[tb/tb_byte_ring_fifo_burst.sv]
`timescale 1ns / 100ps

typedef struct {
	logic [brf_pkg::STAT_W-1:0] status;
	logic [brf_pkg::BYTE_W-1:0] out_byte;
	logic [brf_pkg::LEN_W-1:0]  done_count;
	logic                       last;
	logic [brf_pkg::USED_W-1:0] used_count;
} fifo_result_t;

class burst_fifo_mirror;
	logic [brf_pkg::BYTE_W-1:0] ring[brf_pkg::DEPTH];
	bit                         written[brf_pkg::DEPTH];
	int unsigned                rd_ptr;
	int unsigned                wr_ptr;
	int unsigned                used_bytes;
	int unsigned                burst_left;
	bit                         burst_ok;
	fifo_result_t               due_results[$];
	int                         fail_count;

	function int unsigned wrap(int unsigned p);
		return p % brf_pkg::DEPTH;
	endfunction

	function void push(logic [brf_pkg::STAT_W-1:0] st, logic [brf_pkg::BYTE_W-1:0] b,
		int unsigned done, bit lst);
		fifo_result_t r;
		r.status     = st;
		r.out_byte   = b;
		r.done_count = done[brf_pkg::LEN_W-1:0];
		r.last       = lst;
		r.used_count = used_bytes[brf_pkg::USED_W-1:0];
		due_results.push_back(r);
	endfunction

	// true when every byte a read of len would touch has been written since reset
	function bit reads_defined(int unsigned len);
		for (int unsigned i = 1; i <= len; i++) begin
			if (!written[wrap(rd_ptr + i)]) return 0;
		end
		return 1;
	endfunction

	function void apply_op(logic [brf_pkg::KIND_W-1:0] k, logic [brf_pkg::LEN_W-1:0] len_in,
		logic [brf_pkg::BYTE_W-1:0] b, logic f);
		int unsigned len;
		int unsigned free_bytes;
		int unsigned start_ptr;
		free_bytes = brf_pkg::DEPTH - 1 - used_bytes;
		len = (len_in > brf_pkg::MAX_BURST) ? brf_pkg::MAX_BURST : len_in;
		if (k > brf_pkg::KIND_CLEAR) begin
			push(brf_pkg::ST_OK, 0, 0, 1);
			return;
		end
		if (k == brf_pkg::KIND_ENQ) begin
			if (f) begin
				burst_left = 0;
				burst_ok = 0;
				if (len == 0) begin
					push(brf_pkg::ST_OK, 0, 0, 1);
					return;
				end
				burst_left = len;
				burst_ok = (len <= free_bytes);
			end else if (burst_left == 0) begin
				push(brf_pkg::ST_NO_SPACE, 0, 0, 1);
				return;
			end
			burst_left--;
			if (burst_ok && used_bytes < brf_pkg::DEPTH - 1) begin
				wr_ptr = wrap(wr_ptr + 1);
				ring[wr_ptr] = b;
				written[wr_ptr] = 1;
				used_bytes++;
				push(brf_pkg::ST_OK, 0, 1, burst_left == 0);
			end else begin
				burst_ok = 0;
				push(brf_pkg::ST_NO_SPACE, 0, 0, burst_left == 0);
			end
			if (burst_left == 0) burst_ok = 0;
			return;
		end
		burst_left = 0;
		burst_ok = 0;
		if (k == brf_pkg::KIND_CLEAR) begin
			rd_ptr = 0;
			wr_ptr = 0;
			used_bytes = 0;
			push(brf_pkg::ST_OK, 0, 0, 1);
			return;
		end
		if (len == 0) begin
			push(brf_pkg::ST_OK, 0, 0, 1);
			return;
		end
		if (k == brf_pkg::KIND_RESV) begin
			if (len > free_bytes) begin
				push(brf_pkg::ST_NO_SPACE, 0, 0, 1);
				return;
			end
			wr_ptr = wrap(wr_ptr + len);
			used_bytes += len;
			push(brf_pkg::ST_OK, 0, len, 1);
			return;
		end
		if (len > used_bytes) begin
			push(brf_pkg::ST_NO_DATA, 0, 0, 1);
			return;
		end
		if (k == brf_pkg::KIND_SKIP) begin
			rd_ptr = wrap(rd_ptr + len);
			used_bytes -= len;
			push(brf_pkg::ST_OK, 0, len, 1);
			return;
		end
		start_ptr = rd_ptr;
		if (k == brf_pkg::KIND_DEQ) begin
			rd_ptr = wrap(rd_ptr + len);
			used_bytes -= len;
		end
		for (int unsigned i = 0; i < len; i++) begin
			push(brf_pkg::ST_OK, ring[wrap(start_ptr + i + 1)], len, i + 1 == len);
		end
	endfunction

	function void check_result(logic [brf_pkg::STAT_W-1:0] st, logic [brf_pkg::BYTE_W-1:0] b,
		logic [brf_pkg::LEN_W-1:0] done, logic lst, logic [brf_pkg::USED_W-1:0] used);
		fifo_result_t e;
		if (due_results.size() == 0) begin
			$error("unexpected result: status %0d out_byte %0d", st, b);
			fail_count++;
			return;
		end
		e = due_results.pop_front();
		if (st !== e.status) begin
			$error("status: expected %0d, got %0d", e.status, st);
			fail_count++;
		end
		if (b !== e.out_byte) begin
			$error("out_byte: expected %0d, got %0d", e.out_byte, b);
			fail_count++;
		end
		if (done !== e.done_count) begin
			$error("done_count: expected %0d, got %0d", e.done_count, done);
			fail_count++;
		end
		if (lst !== e.last) begin
			$error("last: expected %0d, got %0d", e.last, lst);
			fail_count++;
		end
		if (used !== e.used_count) begin
			$error("used_count: expected %0d, got %0d", e.used_count, used);
			fail_count++;
		end
	endfunction
endclass

module tb_byte_ring_fifo_burst;
	localparam logic [brf_pkg::KIND_W-1:0] KIND_SPARE_A = 3'd6;
	localparam logic [brf_pkg::KIND_W-1:0] KIND_SPARE_B = 3'd7;
	localparam int ITEM_TARGET = 230;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [15:0] s_tdata;
	logic [3:0]  s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [31:0] m_tdata;
	logic [1:0]  m_tuser;
	logic        m_tlast;

	burst_fifo_mirror mirror = new();
	int  items_sent;
	int  out_hold;
	bit  in_steady;
	bit  out_steady;

	byte_ring_fifo_burst dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	always #10 clk = ~clk;

	initial begin
		#10_000_000;
		$display("tb: failure");
		$finish;
	end

	task automatic send_item(input logic [brf_pkg::KIND_W-1:0] k,
		input logic [brf_pkg::LEN_W-1:0] len, input logic [brf_pkg::BYTE_W-1:0] b,
		input logic f);
		int gap;
		gap = in_steady ? 0 : $urandom_range(0, 4);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {1'b0, b, len};
		s_tuser  <= {f, k};
		do @(posedge clk); while (!s_tready);
		mirror.apply_op(k, len, b, f);
		items_sent++;
		@(negedge clk);
	endtask

	task automatic enq_burst(input int unsigned len, input int unsigned count);
		send_item(brf_pkg::KIND_ENQ, brf_pkg::LEN_W'(len),
			brf_pkg::BYTE_W'($urandom_range(0, 255)), 1'b1);
		for (int unsigned i = 1; i < count; i++) begin
			send_item(brf_pkg::KIND_ENQ, brf_pkg::LEN_W'($urandom_range(0, 127)),
				brf_pkg::BYTE_W'($urandom_range(0, 255)), 1'b0);
		end
	endtask

	// reserve up to full, overshoot once, top off, then try an enqueue into no room
	task automatic fill_ring();
		while (mirror.used_bytes + brf_pkg::MAX_BURST <= brf_pkg::DEPTH - 1) begin
			send_item(brf_pkg::KIND_RESV, brf_pkg::LEN_W'(brf_pkg::MAX_BURST),
				brf_pkg::BYTE_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
		end
		send_item(brf_pkg::KIND_RESV, brf_pkg::LEN_W'(brf_pkg::MAX_BURST),
			brf_pkg::BYTE_W'($urandom_range(0, 255)), 1'b0);
		if (mirror.used_bytes < brf_pkg::DEPTH - 1) begin
			send_item(brf_pkg::KIND_RESV,
				brf_pkg::LEN_W'(brf_pkg::DEPTH - 1 - mirror.used_bytes), 8'h00, 1'b0);
		end
		enq_burst($urandom_range(2, 5), $urandom_range(2, 5));
	endtask

	task automatic read_op(input logic [brf_pkg::KIND_W-1:0] k);
		int unsigned len;
		int unsigned cap;
		logic [brf_pkg::KIND_W-1:0] op;
		op = k;
		cap = (mirror.used_bytes < 16) ? mirror.used_bytes : 16;
		if (mirror.used_bytes == 0 || $urandom_range(0, 5) == 0) begin
			len = mirror.used_bytes + $urandom_range(1, 4);
		end else if (mirror.used_bytes >= brf_pkg::MAX_BURST && $urandom_range(0, 7) == 0) begin
			len = brf_pkg::MAX_BURST;
		end else begin
			len = $urandom_range(1, cap);
		end
		if (len > brf_pkg::MAX_BURST) len = brf_pkg::MAX_BURST;
		if (len <= mirror.used_bytes && !mirror.reads_defined(len)) op = brf_pkg::KIND_SKIP;
		send_item(op, brf_pkg::LEN_W'(len), brf_pkg::BYTE_W'($urandom_range(0, 255)),
			1'($urandom_range(0, 1)));
	endtask

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			mirror.check_result(m_tuser, m_tdata[7:0], m_tdata[14:8], m_tlast,
				m_tdata[24:15]);
			out_hold = out_steady ? 0 : $urandom_range(0, 4);
		end else if (out_hold > 0) begin
			out_hold--;
		end
	end

	always @(negedge clk) begin
		m_tready <= arst_n && (out_hold == 0);
	end

	initial begin
		int unsigned pick;
		int unsigned len;
		int          waited;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = '0;
		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		send_item(brf_pkg::KIND_ENQ, 3, 8'h00, 1'b1);
		send_item(brf_pkg::KIND_ENQ, 0, 8'hFF, 1'b0);
		send_item(brf_pkg::KIND_ENQ, 0, 8'hA5, 1'b0);
		send_item(brf_pkg::KIND_PEEK, 3, 8'h00, 1'b0);
		send_item(brf_pkg::KIND_DEQ, 2, 8'h00, 1'b0);
		send_item(brf_pkg::KIND_DEQ, 5, 8'h00, 1'b0);
		send_item(brf_pkg::KIND_ENQ, 1, 8'h3C, 1'b0);
		send_item(brf_pkg::KIND_ENQ, 4, 8'h81, 1'b1);
		send_item(brf_pkg::KIND_ENQ, 0, 8'h7E, 1'b0);
		send_item(brf_pkg::KIND_DEQ, 1, 8'h00, 1'b0);
		send_item(brf_pkg::KIND_ENQ, 0, 8'h55, 1'b1);
		send_item(brf_pkg::KIND_DEQ, 0, 8'h00, 1'b0);
		send_item(KIND_SPARE_A, 7'h7F, 8'hFF, 1'b1);
		send_item(KIND_SPARE_B, 5, 8'h12, 1'b0);
		send_item(brf_pkg::KIND_SKIP, 1, 8'h00, 1'b0);
		send_item(brf_pkg::KIND_RESV, 7'd127, 8'h00, 1'b0);
		send_item(brf_pkg::KIND_CLEAR, 64, 8'h00, 1'b1);

		fill_ring();
		while (items_sent < ITEM_TARGET) begin
			if ($urandom_range(0, 9) == 0) in_steady = ($urandom_range(0, 2) == 0);
			if ($urandom_range(0, 9) == 0) out_steady = ($urandom_range(0, 2) == 0);
			pick = $urandom_range(0, 99);
			if (pick < 3 && mirror.used_bytes < 600) begin
				fill_ring();
			end else if (pick < 40) begin
				len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, brf_pkg::MAX_BURST)
					: $urandom_range(1, 8);
				if ($urandom_range(0, 19) == 0) len = brf_pkg::MAX_BURST;
				enq_burst(len, ($urandom_range(0, 7) == 0) ? $urandom_range(1, len) : len);
			end else if (pick < 55) begin
				read_op(brf_pkg::KIND_DEQ);
			end else if (pick < 65) begin
				read_op(brf_pkg::KIND_PEEK);
			end else if (pick < 73) begin
				read_op(brf_pkg::KIND_SKIP);
			end else if (pick < 85) begin
				send_item(brf_pkg::KIND_RESV,
					brf_pkg::LEN_W'($urandom_range(1, brf_pkg::MAX_BURST)),
					brf_pkg::BYTE_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
			end else if (pick < 88) begin
				send_item(brf_pkg::KIND_CLEAR, brf_pkg::LEN_W'($urandom_range(0, 127)),
					brf_pkg::BYTE_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
			end else if (pick < 93) begin
				send_item(brf_pkg::KIND_ENQ, brf_pkg::LEN_W'($urandom_range(0, 127)),
					brf_pkg::BYTE_W'($urandom_range(0, 255)), 1'b0);
			end else if (pick < 96) begin
				send_item(brf_pkg::KIND_W'($urandom_range(brf_pkg::KIND_ENQ,
					brf_pkg::KIND_RESV)), 0, brf_pkg::BYTE_W'($urandom_range(0, 255)), 1'b1);
			end else if (pick < 98) begin
				send_item(brf_pkg::KIND_W'($urandom_range(KIND_SPARE_A, KIND_SPARE_B)),
					brf_pkg::LEN_W'($urandom_range(0, 127)),
					brf_pkg::BYTE_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
			end else begin
				read_op(($urandom_range(0, 1) == 0) ? brf_pkg::KIND_DEQ : brf_pkg::KIND_PEEK);
				send_item(brf_pkg::KIND_RESV,
					brf_pkg::LEN_W'($urandom_range(brf_pkg::MAX_BURST + 1, 127)), 8'h00, 1'b0);
			end
		end
		s_tvalid <= 1'b0;

		while (mirror.due_results.size() != 0) @(posedge clk);
		waited = 0;
		while (waited < 10) begin
			@(posedge clk);
			waited++;
		end
		if (mirror.fail_count == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end
endmodule

[byte_ring_fifo_burst.f]
design/brf_pkg.sv
design/brf_front.sv
design/brf_queue.sv
design/brf_back.sv
design/byte_ring_fifo_burst.sv
tb/tb_byte_ring_fifo_burst.sv
